// File: rtl/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// Shared types and constants of the audio peak and RMS level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package apm_pkg;

   localparam int CHANNELS_DEFAULT    = 6;
   localparam int SAMPLE_BITS_DEFAULT = 24;

   localparam int SUM_BITS   = 64;
   localparam int TOTAL_BITS = 32;
   localparam int ROOT_BITS  = SUM_BITS / 2;
   localparam int LEVEL_BITS = 24;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_PUBLISH = 2'd1;
   localparam logic [1:0] OP_BLOCK   = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [2:0]         channel_index;
      logic signed [23:0] sample_value;
      logic [12:0]        block_frames;
   } req_type;

   typedef struct packed {
      logic [2:0]            out_channel;
      logic [LEVEL_BITS-1:0] peak_level;
      logic [LEVEL_BITS-1:0] rms_level;
      logic                  rms_valid;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/apm_divider.sv
// ----------------------------------------------------------------------------
// apm_divider
// Bit-serial restoring divider: one quotient bit per cycle, the dividend
// shifting out of the top of the quotient register as quotient bits enter.
// ----------------------------------------------------------------------------
`default_nettype none

module apm_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [apm_pkg::SUM_BITS-1:0]   dividend,
   input  wire logic [apm_pkg::TOTAL_BITS-1:0] divisor,
   output logic                                done,
   output logic [apm_pkg::SUM_BITS-1:0]        quotient
);
   import apm_pkg::*;

   localparam int CountBits = $clog2(SUM_BITS + 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [CountBits-1:0]    count_ff;
   logic [SUM_BITS-1:0]     quo_ff;
   logic [TOTAL_BITS-1:0]   rem_ff;
   logic [TOTAL_BITS-1:0]   divisor_ff;
   logic [TOTAL_BITS:0]     rem_shift;
   logic [TOTAL_BITS:0]     rem_in;
   logic                    fits;

   assign rem_shift = {rem_ff, quo_ff[SUM_BITS-1]};
   assign fits      = rem_shift >= {1'b0, divisor_ff};
   assign rem_in    = fits ? (rem_shift - {1'b0, divisor_ff}) : rem_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CountBits'(SUM_BITS);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CountBits'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff     <= dividend;
         rem_ff     <= '0;
         divisor_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SUM_BITS-2:0], fits};
         rem_ff <= rem_in[TOTAL_BITS-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/apm_isqrt.sv
// ----------------------------------------------------------------------------
// apm_isqrt
// Digit-by-digit integer square root: two radicand bits enter and one root
// bit leaves per cycle, giving the truncated root.
// ----------------------------------------------------------------------------
`default_nettype none

module apm_isqrt (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [apm_pkg::SUM_BITS-1:0]  radicand,
   output logic                               done,
   output logic [apm_pkg::ROOT_BITS-1:0]      root
);
   import apm_pkg::*;

   localparam int CountBits = $clog2(ROOT_BITS + 1);
   localparam int RemBits   = ROOT_BITS + 2;

   logic                  busy_ff;
   logic                  done_ff;
   logic [CountBits-1:0]  count_ff;
   logic [SUM_BITS-1:0]   rad_ff;
   logic [RemBits-1:0]    rem_ff;
   logic [ROOT_BITS-1:0]  root_ff;
   logic [RemBits+1:0]    rem_shift;
   logic [RemBits+1:0]    trial;
   logic [RemBits+1:0]    rem_in;
   logic                  fits;

   assign rem_shift = {rem_ff, rad_ff[SUM_BITS-1:SUM_BITS-2]};
   assign trial     = {2'b00, root_ff, 2'b01};
   assign fits      = rem_shift >= trial;
   assign rem_in    = fits ? (rem_shift - trial) : rem_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CountBits'(ROOT_BITS);
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == CountBits'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[SUM_BITS-3:0], 2'b00};
         rem_ff  <= rem_in[RemBits-1:0];
         root_ff <= {root_ff[ROOT_BITS-2:0], fits};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

// File: rtl/audio_peak_rms_meter_top.sv
// ----------------------------------------------------------------------------
// audio_peak_rms_meter_top
// Peak and RMS level meter for up to CHANNELS audio channels.
// ----------------------------------------------------------------------------
// A sample request passes through accept, square and accumulate steps;
// block-end and restart requests and ignored channels finish on acceptance.
// A publish request runs load, bit-serial divide, square-root and output
// steps in order, and holds in output while the response register is full.
// A publish whose total is zero skips the divide and square-root steps.
// Synchronous reset clears sums, peaks, frame total and the response valid flag.
`default_nettype none

module audio_peak_rms_meter_top #(
   parameter int CHANNELS    = apm_pkg::CHANNELS_DEFAULT,
   parameter int SAMPLE_BITS = apm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire apm_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output apm_pkg::rsp_type      rsp_data
);
   import apm_pkg::*;

   localparam int ChBits  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int SqBits  = 2 * SAMPLE_BITS;
   localparam logic [ROOT_BITS-1:0] FullScale = ROOT_BITS'(1) << (SAMPLE_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_PUB_LOAD,
      ST_DIVIDE,
      ST_ROOT,
      ST_PUB_OUT
   } state_type;

   state_type                state_ff;
   logic [ChBits-1:0]        ch_ff;
   logic [SAMPLE_BITS-1:0]   mag_ff;
   logic [SqBits-1:0]        sq_ff;
   logic [SUM_BITS-1:0]      sum_ff  [CHANNELS];
   logic [SAMPLE_BITS-1:0]   peak_ff [CHANNELS];
   logic [TOTAL_BITS-1:0]    total_ff;
   logic [SAMPLE_BITS-1:0]   pend_peak_ff;
   logic [ROOT_BITS-1:0]     pend_rms_ff;
   logic                     pend_valid_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic                     accept;
   logic                     ch_ok;
   logic [SAMPLE_BITS-1:0]   raw;
   logic [SAMPLE_BITS-1:0]   mag;
   logic [SqBits-1:0]        square;
   logic [SUM_BITS:0]        sum_add;
   logic [TOTAL_BITS:0]      total_add;
   logic                     div_start;
   logic                     div_done;
   logic [SUM_BITS-1:0]      div_quo;
   logic                     root_start;
   logic                     root_done;
   logic [ROOT_BITS-1:0]     root_val;
   logic                     rsp_free;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign ch_ok     = 32'(req_data.channel_index) < CHANNELS;
   assign raw       = SAMPLE_BITS'($unsigned(req_data.sample_value));
   // The two's-complement negation of the most negative code is itself,
   // which is exactly the full-scale magnitude.
   assign mag       = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
   assign square    = mag_ff * mag_ff;
   assign sum_add   = {1'b0, sum_ff[ch_ff]} + (SUM_BITS + 1)'(sq_ff);
   assign total_add = {1'b0, total_ff} + (TOTAL_BITS + 1)'(req_data.block_frames);
   assign div_start = (state_ff == ST_PUB_LOAD) && (total_ff != '0);
   assign root_start = (state_ff == ST_DIVIDE) && div_done;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   apm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff[ch_ff]),
      .divisor  (total_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   apm_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (div_quo),
      .done     (root_done),
      .root     (root_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i]  <= '0;
            peak_ff[i] <= '0;
         end
      end else begin
         if ((state_ff == ST_PUB_OUT) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (req_data.opcode)
                     OP_SAMPLE: begin
                        if (ch_ok) begin
                           state_ff <= ST_SQUARE;
                        end
                     end
                     OP_PUBLISH: begin
                        if (ch_ok) begin
                           state_ff <= ST_PUB_LOAD;
                        end
                     end
                     OP_BLOCK: begin
                        total_ff <= total_add[TOTAL_BITS] ? '1 : total_add[TOTAL_BITS-1:0];
                     end
                     OP_RESTART: begin
                        total_ff <= '0;
                        for (int i = 0; i < CHANNELS; i++) begin
                           sum_ff[i] <= '0;
                        end
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_SQUARE: begin
               if (mag_ff > peak_ff[ch_ff]) begin
                  peak_ff[ch_ff] <= mag_ff;
               end
               state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               sum_ff[ch_ff] <= sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
               state_ff      <= ST_IDLE;
            end
            ST_PUB_LOAD: begin
               peak_ff[ch_ff] <= '0;
               state_ff       <= (total_ff != '0) ? ST_DIVIDE : ST_PUB_OUT;
            end
            ST_DIVIDE: begin
               if (div_done) begin
                  state_ff <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_done) begin
                  state_ff <= ST_PUB_OUT;
               end
            end
            ST_PUB_OUT: begin
               if (rsp_free) begin
                  rsp_data_ff.out_channel <= 3'(ch_ff);
                  rsp_data_ff.peak_level  <= LEVEL_BITS'(pend_peak_ff);
                  rsp_data_ff.rms_level   <= pend_rms_ff[LEVEL_BITS-1:0];
                  rsp_data_ff.rms_valid   <= pend_valid_ff;
                  state_ff                <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         ch_ff  <= ChBits'(req_data.channel_index);
         mag_ff <= mag;
      end
      if (state_ff == ST_SQUARE) begin
         sq_ff <= square;
      end
      if (state_ff == ST_PUB_LOAD) begin
         pend_peak_ff  <= peak_ff[ch_ff];
         pend_rms_ff   <= '0;
         pend_valid_ff <= (total_ff != '0);
      end
      if ((state_ff == ST_ROOT) && root_done) begin
         pend_rms_ff <= (root_val > FullScale) ? FullScale : root_val;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

   a_root_done_in_root: assert property (@(posedge clock) disable iff (reset)
      root_done |-> (state_ff == ST_ROOT))
      else $error("square root finished outside the root state");

   a_peak_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUB_LOAD) |=> (peak_ff[ch_ff] == '0))
      else $error("channel peak not cleared by publish");

   a_rms_zero_when_invalid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.rms_valid) |-> (rsp_data_ff.rms_level == '0))
      else $error("rms level nonzero without a frame total");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PUB_OUT) && rsp_free) |=> rsp_valid_ff)
      else $error("published levels did not reach the response register");

endmodule

`default_nettype wire
